[rtl/elpc_pkg.sv]
package elpc_pkg;

	localparam logic FUNC_ENCODE = 1'b0;
	localparam logic FUNC_DECODE = 1'b1;

	localparam logic KIND_BYTE = 1'b0;
	localparam logic KIND_SIZE = 1'b1;

	typedef struct packed {
		logic        func;
		logic [31:0] size_in;
		logic [7:0]  byte_in;
	} item_t;

	typedef struct packed {
		logic        kind;
		logic [7:0]  byte_out;
		logic [31:0] size_out;
		logic        last;
	} result_t;

	// One unit of work for the back end: an encoding to serialize, or a finished size.
	typedef struct packed {
		logic        kind;
		logic [1:0]  tier;
		logic [31:0] value;
	} cmd_t;

endpackage

[rtl/elpc_front.sv]
module elpc_front #(
	parameter int ESCAPE_BYTE = 255
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  elpc_pkg::item_t   item,
	output logic              cmd_wr,
	output elpc_pkg::cmd_t    cmd
);

	localparam logic [7:0]  EscByte = 8'(ESCAPE_BYTE);
	localparam logic [31:0] EscL1   = 32'(EscByte);
	localparam logic [31:0] EscL2   = 32'(EscL1 * 32'h0000_0101);
	localparam logic [31:0] EscL3   = 32'(EscL1 * 32'h0001_0101);
	localparam logic [31:0] EscL12  = 32'(EscL1 + EscL2);
	localparam logic [31:0] EscL123 = 32'(EscL12 + EscL3);

	logic [1:0]  tier_q, tier_d;
	logic [2:0]  left_q, left_d;
	logic [31:0] run_q, run_d;
	logic [31:0] field_q, field_d;

	logic        ge1, ge2, ge3;
	logic [1:0]  enc_tier;
	logic [31:0] enc_base;
	logic [31:0] field_next;
	logic [2:0]  left_next;
	logic [31:0] sum;
	logic        dec_done;
	logic [31:0] dec_size;

	// Encoder: the tier comes from three parallel compares against the cumulative levels.
	always_comb begin
		ge1 = item.size_in >= EscL1;
		ge2 = item.size_in >= EscL12;
		ge3 = item.size_in >= EscL123;
		if (ge3) begin
			enc_tier = 2'd3;
			enc_base = EscL123;
		end else if (ge2) begin
			enc_tier = 2'd2;
			enc_base = EscL12;
		end else if (ge1) begin
			enc_tier = 2'd1;
			enc_base = EscL1;
		end else begin
			enc_tier = 2'd0;
			enc_base = '0;
		end
	end

	always_comb begin
		tier_d     = tier_q;
		left_d     = left_q;
		run_d      = run_q;
		field_d    = field_q;
		dec_done   = 1'b0;
		dec_size   = '0;
		field_next = {field_q[23:0], item.byte_in};
		left_next  = left_q - 3'd1;
		sum        = run_q + field_next;
		if (accept && item.func == elpc_pkg::FUNC_DECODE) begin
			if (left_q == 3'd0) begin
				if (item.byte_in == EscByte) begin
					tier_d  = 2'd1;
					left_d  = 3'd2;
					run_d   = EscL1;
					field_d = '0;
				end else begin
					dec_done = 1'b1;
					dec_size = 32'(item.byte_in);
				end
			end else if (left_next != 3'd0) begin
				field_d = field_next;
				left_d  = left_next;
			end else if (tier_q == 2'd1 && sum == EscL12) begin
				tier_d  = 2'd2;
				left_d  = 3'd3;
				run_d   = sum;
				field_d = '0;
			end else if (tier_q == 2'd2 && sum == EscL123) begin
				tier_d  = 2'd3;
				left_d  = 3'd4;
				run_d   = sum;
				field_d = '0;
			end else begin
				dec_done = 1'b1;
				dec_size = sum;
			end
			if (dec_done) begin
				tier_d  = '0;
				left_d  = '0;
				run_d   = '0;
				field_d = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tier_q  <= '0;
			left_q  <= '0;
			run_q   <= '0;
			field_q <= '0;
		end else begin
			tier_q  <= tier_d;
			left_q  <= left_d;
			run_q   <= run_d;
			field_q <= field_d;
		end
	end

	always_comb begin
		cmd_wr = accept && (item.func == elpc_pkg::FUNC_ENCODE || dec_done);
		if (item.func == elpc_pkg::FUNC_ENCODE) begin
			cmd.kind  = elpc_pkg::KIND_BYTE;
			cmd.tier  = enc_tier;
			cmd.value = item.size_in - enc_base;
		end else begin
			cmd.kind  = elpc_pkg::KIND_SIZE;
			cmd.tier  = 2'd0;
			cmd.value = dec_size;
		end
	end

endmodule

[rtl/elpc_cmd_fifo.sv]
module elpc_cmd_fifo #(
	parameter int DEPTH = 4
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            wr,
	input  elpc_pkg::cmd_t  wr_data,
	output logic            full,
	input  logic            rd,
	output elpc_pkg::cmd_t  rd_data,
	output logic            valid
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	elpc_pkg::cmd_t mem_q [DEPTH];
	logic [AW-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]  count_q;

	assign full    = count_q == CW'(DEPTH);
	assign valid   = count_q != '0;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (rd) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			if (wr && !rd) begin
				count_q <= count_q + CW'(1);
			end else if (rd && !wr) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

[rtl/elpc_back.sv]
module elpc_back #(
	parameter int ESCAPE_BYTE = 255
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	input  elpc_pkg::cmd_t    cmd,
	output logic              cmd_pop,
	output elpc_pkg::result_t result,
	output logic              empty,
	input  logic              pop
);

	localparam logic [7:0] EscByte = 8'(ESCAPE_BYTE);

	logic [3:0]        idx_q;
	logic              ovalid_q;
	elpc_pkg::result_t out_q;

	logic              load;
	logic [3:0]        nbytes;
	logic [3:0]        nesc;
	logic [3:0]        pos;
	logic [7:0]        digit;
	logic              final_beat;
	elpc_pkg::result_t nxt;

	always_comb begin
		case (cmd.tier)
			2'd0: begin
				nbytes = 4'd1;
				nesc   = 4'd0;
			end
			2'd1: begin
				nbytes = 4'd3;
				nesc   = 4'd1;
			end
			2'd2: begin
				nbytes = 4'd6;
				nesc   = 4'd3;
			end
			default: begin
				nbytes = 4'd10;
				nesc   = 4'd6;
			end
		endcase
		pos = nbytes - 4'd1 - idx_q;
		case (pos[1:0])
			2'd0:    digit = cmd.value[7:0];
			2'd1:    digit = cmd.value[15:8];
			2'd2:    digit = cmd.value[23:16];
			default: digit = cmd.value[31:24];
		endcase
		final_beat = cmd.kind == elpc_pkg::KIND_SIZE || idx_q == nbytes - 4'd1;
		nxt.kind   = cmd.kind;
		nxt.last   = final_beat;
		if (cmd.kind == elpc_pkg::KIND_SIZE) begin
			nxt.byte_out = '0;
			nxt.size_out = cmd.value;
		end else begin
			nxt.byte_out = (idx_q < nesc) ? EscByte : digit;
			nxt.size_out = '0;
		end
	end

	// The output register takes a beat whenever it is empty or being drained.
	assign load    = !ovalid_q || pop;
	assign cmd_pop = load && cmd_valid && final_beat;
	assign empty   = !ovalid_q;
	assign result  = out_q;

	always_ff @(posedge clk) begin
		if (load && cmd_valid) begin
			out_q <= nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
			idx_q    <= '0;
		end else if (load) begin
			ovalid_q <= cmd_valid;
			if (cmd_valid) begin
				idx_q <= final_beat ? 4'd0 : idx_q + 4'd1;
			end
		end
	end

endmodule

[rtl/escaped_length_prefix_codec_unit.sv]
// Escaped length prefix codec.
// Input queue port: push an item while full is low. With func at encode, size_in
// becomes a big-endian prefix of 1, 3, 6 or 10 byte results (kind 0, last on the
// final one). With func at decode, byte_in is one byte of a prefix; the byte that
// completes a prefix yields one size result (kind 1, last set), other bytes yield
// nothing. Result queue port: the oldest result shows while empty is low and
// leaves on pop.
// Throughput: one item accepted per cycle while full is low and one result beat
// delivered per cycle while the receiver pops; an encoding holds the back end until
// all its bytes are out, so a steady stream of encodes is bound by the serializer.
// A result reaches the port through the command queue write at the accepting edge
// and then the output register load, which waits while the receiver stalls.
// When the receiver stalls, the output register holds its beat, the back end stops,
// and the command queue (CMD_DEPTH entries) absorbs items until full rises.
// Decode bytes that finish no prefix never need queue space but still wait on full.
// Reset clears the decoder state, the command queue and the output register.
module escaped_length_prefix_codec_unit #(
	parameter int ESCAPE_BYTE = 255,
	parameter int CMD_DEPTH   = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  elpc_pkg::item_t   item,
	output logic              empty,
	input  logic              pop,
	output elpc_pkg::result_t result
);

	logic           accept;
	logic           cmd_wr;
	elpc_pkg::cmd_t cmd_in;
	logic           cmd_valid;
	logic           cmd_pop;
	elpc_pkg::cmd_t cmd_head;

	assign accept = push && !full;

	elpc_front #(
		.ESCAPE_BYTE(ESCAPE_BYTE)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.item   (item),
		.cmd_wr (cmd_wr),
		.cmd    (cmd_in)
	);

	elpc_cmd_fifo #(
		.DEPTH(CMD_DEPTH)
	) u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (cmd_wr),
		.wr_data (cmd_in),
		.full    (full),
		.rd      (cmd_pop),
		.rd_data (cmd_head),
		.valid   (cmd_valid)
	);

	elpc_back #(
		.ESCAPE_BYTE(ESCAPE_BYTE)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd       (cmd_head),
		.cmd_pop   (cmd_pop),
		.result    (result),
		.empty     (empty),
		.pop       (pop)
	);

	a_reset_empty: assert property (@(posedge clk) !arst_n |=> empty)
		else $error("result queue not empty during reset");

	a_pop_has_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |-> cmd_valid)
		else $error("command taken from an empty queue");

	a_size_beat: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.kind == elpc_pkg::KIND_SIZE) |->
		(result.last && result.byte_out == 8'd0))
		else $error("size beat without last or with a byte");

	a_byte_beat: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.kind == elpc_pkg::KIND_BYTE) |-> result.size_out == 32'd0)
		else $error("byte beat carries a size");

endmodule
